/* rtl/core/basis_series_evaluator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the basis series evaluator
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while the synchronous active-low reset is applied.
// ----------------------------------------------------------------------------
`ifndef BASIS_SERIES_EVALUATOR_UNIT_ASSERT_SVH
`define BASIS_SERIES_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define BSE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define BSE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

/* rtl/core/bse_pkg.sv */
// ----------------------------------------------------------------------------
// Basis series evaluator package
// Widths, register codes and the command and status structures shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bse_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ORDER_W = 5;
    localparam int unsigned SCALE_W = 31;
    localparam int unsigned ADDR_W  = 4;

    localparam logic [SCALE_W-1:0] INV_SCALE_RST = SCALE_W'(65536);

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_ARG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INV_SCALE  = 2'd1;
    localparam logic [1:0] REG_BASIS_KIND = 2'd2;
    localparam logic [1:0] REG_DERIV_MODE = 2'd3;

    // Operand pair presented to the shared multiplier.
    typedef enum logic [1:0] {
        OP_NORM,
        OP_STEP,
        OP_NFX,
        OP_COEF
    } t_op_sel;

    // Source of the basis value.
    typedef enum logic [1:0] {
        B_CUR,
        B_ZERO,
        B_PROD
    } t_b_sel;

    typedef struct packed {
        logic [WORD_W-1:0]  arg_offset;
        logic [SCALE_W-1:0] inv_scale;
        logic               basis_kind;
        logic               deriv_mode;
    } t_cfg;

    typedef struct packed {
        logic    load;
        logic    mul_start;
        t_op_sel op_sel;
        logic    wb_x;
        logic    init;
        logic    step_wb;
        logic    wb_b;
        t_b_sel  b_sel;
        logic    wb_acc;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic deriv;
        logic n_zero;
        logic cnt_zero;
        logic last;
    } t_status;

endpackage

/* rtl/core/bse_qmul.sv */
// ----------------------------------------------------------------------------
// Basis series evaluator fixed-point multiplier
// Iterative signed 64 x 64 fixed-point product on one 32 x 32 multiplier,
// truncated toward zero and saturated to the signed 64-bit range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "basis_series_evaluator_unit_assert.svh"

module bse_qmul
    import bse_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_result
);

    localparam logic [2:0] LAST_CNT = 3'd5;

    logic                     r_busy;
    logic [2:0]               r_cnt;
    logic                     r_done;
    logic                     r_neg;
    logic [DATA_W-1:0]        r_ua;
    logic [DATA_W-1:0]        r_ub;
    logic [DATA_W-1:0]        r_pp;
    logic [2*DATA_W-1:0]      r_acc;
    logic signed [DATA_W-1:0] r_res;

    logic [WORD_W-1:0]   w_op_a;
    logic [WORD_W-1:0]   w_op_b;
    logic [2*DATA_W-1:0] w_addend;
    logic [DATA_W-1:0]   w_rlo;
    logic                w_ovf;
    logic [DATA_W-1:0]   w_res;

    // Partial products in the order low-low, low-high, high-low, high-high.
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_op_a = r_ua[WORD_W-1:0];
                w_op_b = r_ub[WORD_W-1:0];
            end
            2'd1: begin
                w_op_a = r_ua[WORD_W-1:0];
                w_op_b = r_ub[DATA_W-1:WORD_W];
            end
            2'd2: begin
                w_op_a = r_ua[DATA_W-1:WORD_W];
                w_op_b = r_ub[WORD_W-1:0];
            end
            default: begin
                w_op_a = r_ua[DATA_W-1:WORD_W];
                w_op_b = r_ub[DATA_W-1:WORD_W];
            end
        endcase
    end

    // The product registered in the previous cycle, placed at its weight.
    always_comb begin
        case (r_cnt) inside
            3'd1:       w_addend = {{DATA_W{1'b0}}, r_pp};
            3'd2, 3'd3: w_addend = {{WORD_W{1'b0}}, r_pp, {WORD_W{1'b0}}};
            3'd4:       w_addend = {r_pp, {DATA_W{1'b0}}};
            default:    w_addend = '0;
        endcase
    end

    always_comb begin
        w_rlo = r_acc[DATA_W-1+FRAC_BITS:FRAC_BITS];
        w_ovf = (|r_acc[2*DATA_W-1:DATA_W+FRAC_BITS])
              | (r_neg ? (w_rlo[DATA_W-1] & (|w_rlo[DATA_W-2:0])) : w_rlo[DATA_W-1]);
        if (w_ovf) begin
            w_res = r_neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            w_res = r_neg ? (~w_rlo + DATA_W'(1)) : w_rlo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_ua  <= i_a[DATA_W-1] ? (~i_a + DATA_W'(1)) : i_a;
            r_ub  <= i_b[DATA_W-1] ? (~i_b + DATA_W'(1)) : i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp  <= w_op_a * w_op_b;
            r_acc <= r_acc + w_addend;
            if (r_cnt == LAST_CNT) begin
                r_res <= w_res;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `BSE_ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, i_start, !r_busy)
    `BSE_ASSERT_NXT(a_done_is_pulse, i_clk, i_rst_n, r_done, !r_done)
    `BSE_ASSERT_IMP(a_cnt_in_range, i_clk, i_rst_n, r_busy, r_cnt <= LAST_CNT)

endmodule

/* rtl/core/bse_dp.sv */
// ----------------------------------------------------------------------------
// Basis series evaluator datapath
// Term registers, recurrence state, saturating accumulator and result
// register, built around the shared fixed-point multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_dp
    import bse_pkg::*;
#(
    parameter int unsigned MAX_ORDER = 31,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic signed [WORD_W-1:0] i_arg_value,
    input  logic signed [WORD_W-1:0] i_coefficient,
    input  logic [ORDER_W-1:0]       i_term_order,
    input  logic                     i_last_term,
    output logic signed [DATA_W-1:0] o_series_sum,
    output logic                     o_arg_clamped
);

    localparam int unsigned NW = $clog2(MAX_ORDER + 1);
    localparam int unsigned OW = (NW > ORDER_W) ? NW : ORDER_W;
    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] FX_NEG = -FX_ONE;
    localparam logic signed [DATA_W-1:0] S_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_add = s[DATA_W] ? S_MIN : S_MAX;
        end else begin
            sat_add = s[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_sub = s[DATA_W] ? S_MIN : S_MAX;
        end else begin
            sat_sub = s[DATA_W-1:0];
        end
    endfunction

    logic signed [DATA_W-1:0] r_d;
    logic signed [WORD_W-1:0] r_c;
    logic [NW-1:0]            r_n;
    logic                     r_last;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_step_op;
    logic signed [DATA_W-1:0] r_cur;
    logic signed [DATA_W-1:0] r_prev;
    logic [NW-1:0]            r_cnt;
    logic signed [DATA_W-1:0] r_b;
    logic signed [DATA_W-1:0] r_acc;
    logic                     r_clamp_seen;
    logic signed [DATA_W-1:0] r_out_sum;
    logic                     r_out_clamp;

    logic [OW-1:0]            w_n_ext;
    logic [OW-1:0]            w_n_cl;
    logic signed [DATA_W-1:0] w_mul_a;
    logic signed [DATA_W-1:0] w_mul_b;
    logic                     w_mul_done;
    logic signed [DATA_W-1:0] w_prod;
    logic                     w_hi;
    logic                     w_lo;
    logic signed [DATA_W-1:0] w_xc;
    logic signed [DATA_W-1:0] w_two;
    logic                     w_flag;
    logic [NW-1:0]            w_m;

    assign w_n_ext = OW'(i_term_order);
    assign w_n_cl  = (w_n_ext > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : w_n_ext;

    always_comb begin
        case (i_cmd.op_sel)
            OP_NORM: begin
                w_mul_a = r_d;
                w_mul_b = {{(DATA_W-SCALE_W){1'b0}}, i_cfg.inv_scale};
            end
            OP_STEP: begin
                w_mul_a = r_step_op;
                w_mul_b = r_cur;
            end
            OP_NFX: begin
                w_mul_a = DATA_W'(r_n) << FRAC_BITS;
                w_mul_b = r_cur;
            end
            default: begin
                w_mul_a = r_b;
                w_mul_b = {{(DATA_W-WORD_W){r_c[WORD_W-1]}}, r_c};
            end
        endcase
    end

    bse_qmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_qmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .o_done   (w_mul_done),
        .o_result (w_prod)
    );

    // Chebyshev arguments are pinned to the interval from minus one to one.
    always_comb begin
        w_hi   = r_x > FX_ONE;
        w_lo   = r_x < FX_NEG;
        w_flag = i_cfg.basis_kind & (w_hi | w_lo);
        if (i_cfg.basis_kind && w_hi) begin
            w_xc = FX_ONE;
        end else if (i_cfg.basis_kind && w_lo) begin
            w_xc = FX_NEG;
        end else begin
            w_xc = r_x;
        end
        w_two = w_xc <<< 1;
        if (i_cfg.deriv_mode) begin
            w_m = (r_n == '0) ? '0 : r_n - NW'(1);
        end else begin
            w_m = r_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d    <= {{(DATA_W-WORD_W){i_arg_value[WORD_W-1]}}, i_arg_value}
                    - {{(DATA_W-WORD_W){i_cfg.arg_offset[WORD_W-1]}}, i_cfg.arg_offset};
            r_c    <= i_coefficient;
            r_n    <= w_n_cl[NW-1:0];
            r_last <= i_last_term;
        end
        if (i_cmd.wb_x) begin
            r_x <= w_prod;
        end
        if (i_cmd.init) begin
            r_step_op <= i_cfg.basis_kind ? w_two : w_xc;
            r_prev    <= FX_ONE;
            if (!i_cfg.basis_kind || w_m == '0) begin
                r_cur <= FX_ONE;
                r_cnt <= w_m;
            end else begin
                r_cur <= i_cfg.deriv_mode ? w_two : w_xc;
                r_cnt <= w_m - NW'(1);
            end
        end
        if (i_cmd.step_wb) begin
            r_cur  <= i_cfg.basis_kind ? sat_sub(w_prod, r_prev) : w_prod;
            r_prev <= r_cur;
            r_cnt  <= r_cnt - NW'(1);
        end
        if (i_cmd.wb_b) begin
            case (i_cmd.b_sel)
                B_ZERO:  r_b <= '0;
                B_PROD:  r_b <= w_prod;
                default: r_b <= r_cur;
            endcase
        end
        if (i_cmd.emit) begin
            r_out_sum   <= r_acc;
            r_out_clamp <= r_clamp_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_clamp_seen <= 1'b0;
        end else begin
            if (i_cmd.init && w_flag) begin
                r_clamp_seen <= 1'b1;
            end
            if (i_cmd.wb_acc) begin
                r_acc <= sat_add(r_acc, w_prod);
            end
            if (i_cmd.emit) begin
                r_acc        <= '0;
                r_clamp_seen <= 1'b0;
            end
        end
    end

    assign o_status.mul_done = w_mul_done;
    assign o_status.deriv    = i_cfg.deriv_mode;
    assign o_status.n_zero   = (r_n == '0);
    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_status.last     = r_last;

    assign o_series_sum  = r_out_sum;
    assign o_arg_clamped = r_out_clamp;

endmodule

/* rtl/core/bse_ctrl.sv */
// ----------------------------------------------------------------------------
// Basis series evaluator controller
// Sequences normalization, the basis recurrence, derivative scaling,
// coefficient weighting and result delivery for one term at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_ctrl
    import bse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_NORM    = 4'd1;
    localparam logic [3:0] S_NORM_W  = 4'd2;
    localparam logic [3:0] S_SETUP   = 4'd3;
    localparam logic [3:0] S_LOOP    = 4'd4;
    localparam logic [3:0] S_LOOP_W  = 4'd5;
    localparam logic [3:0] S_DERIV   = 4'd6;
    localparam logic [3:0] S_DERIV_W = 4'd7;
    localparam logic [3:0] S_COEF    = 4'd8;
    localparam logic [3:0] S_COEF_W  = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_NORM;
                end
            end
            S_NORM: begin
                w_cmd.mul_start = 1'b1;
                w_cmd.op_sel    = OP_NORM;
                n_state         = S_NORM_W;
            end
            S_NORM_W: begin
                if (i_status.mul_done) begin
                    w_cmd.wb_x = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                w_cmd.init = 1'b1;
                n_state    = S_LOOP;
            end
            S_LOOP: begin
                if (i_status.cnt_zero) begin
                    n_state = S_DERIV;
                end else begin
                    w_cmd.mul_start = 1'b1;
                    w_cmd.op_sel    = OP_STEP;
                    n_state         = S_LOOP_W;
                end
            end
            S_LOOP_W: begin
                if (i_status.mul_done) begin
                    w_cmd.step_wb = 1'b1;
                    n_state       = S_LOOP;
                end
            end
            S_DERIV: begin
                if (!i_status.deriv) begin
                    w_cmd.wb_b  = 1'b1;
                    w_cmd.b_sel = B_CUR;
                    n_state     = S_COEF;
                end else if (i_status.n_zero) begin
                    w_cmd.wb_b  = 1'b1;
                    w_cmd.b_sel = B_ZERO;
                    n_state     = S_COEF;
                end else begin
                    w_cmd.mul_start = 1'b1;
                    w_cmd.op_sel    = OP_NFX;
                    n_state         = S_DERIV_W;
                end
            end
            S_DERIV_W: begin
                if (i_status.mul_done) begin
                    w_cmd.wb_b  = 1'b1;
                    w_cmd.b_sel = B_PROD;
                    n_state     = S_COEF;
                end
            end
            S_COEF: begin
                w_cmd.mul_start = 1'b1;
                w_cmd.op_sel    = OP_COEF;
                n_state         = S_COEF_W;
            end
            S_COEF_W: begin
                if (i_status.mul_done) begin
                    w_cmd.wb_acc = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                // A closing term waits here only while the previous result is
                // still held by the downstream side.
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    w_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/basis_series_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// Basis series evaluator
// The unit takes one series term per transaction (argument, coefficient,
// order, last-term mark), normalizes the argument as (arg - arg_offset) times
// inv_scale, evaluates a power or Chebyshev first-kind basis, or its
// derivative, up to the term's order, weights it by the coefficient and adds
// it to a saturating 64-bit fixed-point sum. A term with last_term set
// produces one output transaction carrying the sum and a flag that tells
// whether any Chebyshev argument of that sum lay outside plus or minus one;
// the sum and flag are then cleared. Terms are processed one at a time: all
// arithmetic runs on one iterative fixed-point multiplier. A term runs the
// normalization product, one product per recurrence step (the order in power
// mode, the order less one for the Chebyshev value, less one more in
// derivative mode), the derivative scaling product when it applies, and the
// coefficient product. The output sits in its own register, so a new term is
// accepted while a finished sum still waits to be taken. Configuration
// registers sit on an APB-style port at byte addresses 0 (arg_offset),
// 4 (inv_scale), 8 (basis_kind) and 12 (derivative_mode); the user must write
// them only while the unit is idle, as the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module basis_series_evaluator_unit
    import bse_pkg::*;
#(
    parameter int unsigned MAX_ORDER = 31,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [WORD_W-1:0]        pwdata,
    output logic [WORD_W-1:0]        prdata,
    output logic                     pready,
    // Term input channel.
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [WORD_W-1:0] i_arg_value,
    input  logic signed [WORD_W-1:0] i_coefficient,
    input  logic [ORDER_W-1:0]       i_term_order,
    input  logic                     i_last_term,
    // Result output channel.
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_series_sum,
    output logic                     o_arg_clamped
);

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_wr;

    // The port never inserts wait states, so a write lands in the access cycle.
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arg_offset <= '0;
            r_cfg.inv_scale  <= INV_SCALE_RST;
            r_cfg.basis_kind <= 1'b0;
            r_cfg.deriv_mode <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_ARG_OFFSET: r_cfg.arg_offset <= pwdata;
                REG_INV_SCALE:  r_cfg.inv_scale  <= pwdata[SCALE_W-1:0];
                REG_BASIS_KIND: r_cfg.basis_kind <= pwdata[0];
                REG_DERIV_MODE: r_cfg.deriv_mode <= pwdata[0];
                default:        r_cfg.deriv_mode <= r_cfg.deriv_mode;
            endcase
        end
    end

    // Reads return the stored value, zero-extended to the bus width.
    always_comb begin
        unique case (paddr[3:2])
            REG_ARG_OFFSET: prdata = r_cfg.arg_offset;
            REG_INV_SCALE:  prdata = {{(WORD_W-SCALE_W){1'b0}}, r_cfg.inv_scale};
            REG_BASIS_KIND: prdata = {{(WORD_W-1){1'b0}}, r_cfg.basis_kind};
            REG_DERIV_MODE: prdata = {{(WORD_W-1){1'b0}}, r_cfg.deriv_mode};
            default:        prdata = '0;
        endcase
    end

    // The controller owns both handshakes and steps the datapath through the
    // multiply sequence of a term.
    bse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the term, the recurrence state, the running sum and
    // the result register.
    bse_dp #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_arg_value   (i_arg_value),
        .i_coefficient (i_coefficient),
        .i_term_order  (i_term_order),
        .i_last_term   (i_last_term),
        .o_series_sum  (o_series_sum),
        .o_arg_clamped (o_arg_clamped)
    );

endmodule
